// ----- src/spms_pkg.sv -----
// Package for the shared pool multi-stack unit: operation codes, default sizes
// and the command struct between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spms_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int NUM_STACKS_DEF = 4;
  localparam int POOL_SLOTS_DEF = 64;
  localparam int DATA_BITS_DEF  = 32;

  // Fixed field widths of the request and result channels.
  localparam int SID_FIELD_W = 2;
  localparam int WORD_W      = 32;

  // Operation codes.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the request and start the slot read.
    logic commit;   // Apply the update and load the result register.
  } spms_cmd_t;

endpackage

`default_nettype wire

// ----- src/spms_in_if.sv -----
// Request channel interface of the shared pool multi-stack unit.
// Depends on spms_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spms_in_if;
  import spms_pkg::*;

  logic                   valid;
  logic                   ready;
  opcode_t                opcode;
  logic [SID_FIELD_W-1:0] stack_id;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output opcode, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input opcode, input stack_id, input push_value,
                  output ready);
endinterface

`default_nettype wire

// ----- src/spms_out_if.sv -----
// Result channel interface of the shared pool multi-stack unit.
// Depends on spms_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spms_out_if;
  import spms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     success;
  logic signed [WORD_W-1:0] pop_value;

  modport source (output valid, output success, output pop_value, input ready);
  modport sink   (input valid, input success, input pop_value, output ready);
endinterface

`default_nettype wire

// ----- src/spms_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/spms_ctrl.sv -----
// Controller of the shared pool multi-stack unit: request and result handshakes
// and the command sequence for the datapath. Depends on spms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spms_pkg::spms_cmd_t      cmd
);
  import spms_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- src/spms_dp.sv -----
// Datapath of the shared pool multi-stack unit: slot data and link RAMs, stack
// tops, free-list head and the result register. Depends on spms_pkg, spms_ram.
`timescale 1ns / 1ps
`default_nettype none

module spms_dp #(
  parameter int NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
  parameter int POOL_SLOTS = spms_pkg::POOL_SLOTS_DEF,
  parameter int DATA_BITS  = spms_pkg::DATA_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire spms_pkg::spms_cmd_t                   cmd,
  input  wire spms_pkg::opcode_t                     in_opcode,
  input  wire logic [spms_pkg::SID_FIELD_W-1:0]      in_stack_id,
  input  wire logic signed [spms_pkg::WORD_W-1:0]    in_push_value,
  output logic                                       out_success,
  output logic signed [spms_pkg::WORD_W-1:0]         out_pop_value
);
  import spms_pkg::*;

  localparam int ADDR_W = $clog2(POOL_SLOTS);
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);
  localparam int SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

  // Stack tops, free-list head and the high-water mark of slots ever taken.
  // Slots at or above the mark are taken to link to their index plus one.
  logic [LINK_W-1:0] stack_top_r [NUM_STACKS];
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [LINK_W-1:0] hw_r, hw_nxt;

  // Latched request.
  opcode_t           op_r;
  logic [SID_W-1:0]  sid_r;
  logic              sid_ok_r;
  logic [WORD_W-1:0] value_r;
  logic [LINK_W-1:0] addr_r;

  logic              sid_ok_in;
  logic [SID_W-1:0]  sid_in;
  logic [LINK_W-1:0] top_in;
  logic [LINK_W-1:0] addr_in;

  logic [DATA_BITS-1:0] data_q;
  logic [LINK_W-1:0]    link_q;
  logic [LINK_W-1:0]    link_eff;
  logic [LINK_W-1:0]    link_next;
  logic                 slot_ok;
  logic                 do_push;
  logic                 do_pop;
  logic                 link_we;
  logic [LINK_W-1:0]    link_wdata;

  logic [DATA_BITS+WORD_W-1:0] push_ext;
  logic [DATA_BITS+WORD_W-1:0] pop_ext;

  // Stack selection and read address for the request being accepted.
  assign sid_ok_in = ({{(32 - SID_FIELD_W){1'b0}}, in_stack_id} < 32'(NUM_STACKS));
  assign sid_in    = SID_W'(in_stack_id);
  assign top_in    = sid_ok_in ? stack_top_r[sid_in] : NULL_LINK;
  assign addr_in   = (in_opcode == OP_POP) ? top_in : free_head_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_opcode;
      sid_r    <= sid_in;
      sid_ok_r <= sid_ok_in;
      value_r  <= in_push_value;
      addr_r   <= addr_in;
    end
  end

  // Slot memories, both read at the captured address.
  spms_ram #(.WIDTH(DATA_BITS), .DEPTH(POOL_SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (addr_r[ADDR_W-1:0]),
    .wdata (push_ext[DATA_BITS-1:0]),
    .re    (cmd.capture),
    .raddr (addr_in[ADDR_W-1:0]),
    .rdata (data_q)
  );

  spms_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (addr_r[ADDR_W-1:0]),
    .wdata (link_wdata),
    .re    (cmd.capture),
    .raddr (addr_in[ADDR_W-1:0]),
    .rdata (link_q)
  );

  // Link of the addressed slot; an untouched slot links to the next index.
  assign link_eff  = (addr_r >= hw_r) ? (addr_r + LINK_W'(1)) : link_q;
  assign link_next = (link_eff < NULL_LINK) ? link_eff : NULL_LINK;

  assign slot_ok = sid_ok_r && (addr_r < NULL_LINK);
  assign do_push = cmd.commit && slot_ok && (op_r == OP_PUSH);
  assign do_pop  = cmd.commit && slot_ok && (op_r == OP_POP);

  // A push links the slot to the old top, a pop links it to the free head.
  assign link_we    = do_push || do_pop;
  assign link_wdata = do_push ? stack_top_r[sid_r] : free_head_r;

  // Sign-extend the pushed word to the stored width; zero-extend on the way out.
  assign push_ext = {{DATA_BITS{value_r[WORD_W-1]}}, value_r};
  assign pop_ext  = {{WORD_W{1'b0}}, data_q};

  // Free-list head and high-water mark.
  always_comb begin
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    if (do_push) begin
      free_head_nxt = link_next;
      if (addr_r == hw_r) begin
        hw_nxt = hw_r + LINK_W'(1);
      end
    end else if (do_pop) begin
      free_head_nxt = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      hw_r        <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_top_r[i] <= NULL_LINK;
      end
    end else begin
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      if (do_push) begin
        stack_top_r[sid_r] <= addr_r;
      end else if (do_pop) begin
        stack_top_r[sid_r] <= link_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_success   <= slot_ok;
      out_pop_value <= do_pop ? pop_ext[WORD_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ----- src/shared_pool_multi_stack_unit.sv -----
// Shared pool multi-stack unit: a request is accepted in IDLE; the acceptance edge
// starts the registered read of the slot link and data RAMs; the commit in EXEC
// writes back and loads the result register, which presents it. One request
// is in flight at a time, so no new request is accepted before the last is
// written back; a waiting result stalls the write-back and the next acceptance.
// Reset (synchronous, active low) empties every stack and rebuilds the free list
// at once; slot data is undefined until pushed. Depends on all files in src.
`timescale 1ns / 1ps
`default_nettype none

module shared_pool_multi_stack_unit #(
  parameter int NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
  parameter int POOL_SLOTS = spms_pkg::POOL_SLOTS_DEF,
  parameter int DATA_BITS  = spms_pkg::DATA_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  spms_in_if.sink     in_ch,
  spms_out_if.source  out_ch
);
  import spms_pkg::*;

  spms_cmd_t cmd;

  // Handshake and sequencing.
  spms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Stack storage and update logic.
  spms_dp #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_SLOTS (POOL_SLOTS),
    .DATA_BITS  (DATA_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_opcode     (in_ch.opcode),
    .in_stack_id   (in_ch.stack_id),
    .in_push_value (in_ch.push_value),
    .out_success   (out_ch.success),
    .out_pop_value (out_ch.pop_value)
  );

endmodule

`default_nettype wire
